// File: rtl/swaf_pkg.sv
// Shared types and constants for the sliding-window anagram finder.
// Holds input kind codes, pipeline operation codes and the result word layout.
// No dependencies; used by sliding_window_anagram_finder_core.
`default_nettype none

package swaf_pkg;

  // Fixed field widths of the stream words.
  localparam int LETTER_W    = 5;
  localparam int START_W     = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int KIND_W      = 2;

  // Kind of an input word, carried on in_tuser. Code 3 has no meaning.
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2
  } kind_t;

  // Work that a word still owes to the counter memories.
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_PATTERN = 2'd2,
    OP_TEXT    = 2'd3
  } op_t;

  // One word in flight through the counter pipeline.
  typedef struct packed {
    op_t                 op;
    logic [LETTER_W-1:0] letter;
    logic                full;      // a letter leaves the window
    logic                win_done;  // the window is complete after this letter
    logic [START_W-1:0]  start;     // start index of that window
    logic                status;    // word was ignored
  } stage_t;

  // One result word.
  typedef struct packed {
    logic               match;
    logic [START_W-1:0] window_start;
    logic               status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/sliding_window_anagram_finder_core.sv
// Top level of the sliding-window anagram finder: control registers, letter ring,
// per-letter counter memories with forwarding, and the result queue.
// Depends on swaf_pkg.
`default_nettype none

// The block takes one word per clock cycle while in_tready is high and answers every word
// with exactly one result. The result passes the s1 and s2 registers and the result queue
// before it is offered on the output and taken while out_tready is high. A word passes three
// steps: its control state and the letter ring (one write and one read port) are
// handled in the accept cycle, the two per-letter counter memories (entering letters
// and pattern or leaving letters, one write port each, read at the new and the departing letter)
// are read in the next cycle, and the balance update and match decision follow in the
// cycle after that, with the previous update forwarded. A four-word result queue lets
// input continue while results wait. A clear word drops all counters through
// per-letter valid bits, so no clearing pass is needed after reset or clear.
module sliding_window_anagram_finder_core #(
  parameter int MAX_PATTERN   = 256,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [swaf_pkg::IN_TDATA_W-1:0]     in_tdata,   // [4:0] letter
  input  wire logic [swaf_pkg::KIND_W-1:0]         in_tuser,   // [1:0] kind
  // Result stream.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [swaf_pkg::OUT_TDATA_W-1:0]         out_tdata,  // [0] match, [32:1] window_start
  output logic                                     out_tuser   // [0] status
);

  localparam int RW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PW = $clog2(MAX_PATTERN + 1);
  localparam int SW = $clog2(MAX_PATTERN) + 1;
  localparam int BW = $clog2(MAX_PATTERN + 1) + 1;
  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam int DW = $clog2(ALPHABET_SIZE + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FW = 2;
  localparam int CW = 3;
  localparam int LW = swaf_pkg::LETTER_W;
  localparam int TW = swaf_pkg::START_W;

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  logic                  accept;
  swaf_pkg::kind_t       kind;
  logic [LW-1:0]         letter;
  logic                  letter_ok;

  logic [PW-1:0]         pat_len_r, pat_len_nxt;
  logic [TW-1:0]         pos_r, pos_nxt;
  logic                  started_r, started_nxt;
  logic [RW-1:0]         head_r, head_nxt;
  logic                  wrapped_r, wrapped_nxt;

  logic                  full;
  logic [TW-1:0]         pos_plus;
  logic [SW-1:0]         old_sum;
  logic [RW-1:0]         old_slot;
  logic [RW-1:0]         head_inc;
  logic                  ring_we;

  logic [LW-1:0]         ring_mem [MAX_PATTERN];
  logic [LW-1:0]         ring_q_r;

  swaf_pkg::stage_t      s1_nxt, s1_r, s2_r;
  logic                  s1_v_r, s2_v_r;
  logic [LW-1:0]         s2_gone_r;

  logic [BW-1:0]         cnt_a_mem [ALPHABET_SIZE];
  logic [BW-1:0]         cnt_b_mem [ALPHABET_SIZE];
  logic [BW-1:0]         a_l_q_r, a_g_q_r, b_l_q_r, b_g_q_r;
  logic [AW-1:0]         idx_l1, idx_g1, idx_l2, idx_g2;

  logic [ALPHABET_SIZE-1:0] a_valid_r, b_valid_r;
  logic                  a_byp_v_r, b_byp_v_r;
  logic [AW-1:0]         a_byp_addr_r, b_byp_addr_r;
  logic [BW-1:0]         a_byp_data_r, b_byp_data_r;

  logic [BW-1:0]         a_l, a_g, b_l, b_g;
  logic [BW-1:0]         bal_l, bal_g;
  logic                  a_we, b_we;
  logic [AW-1:0]         a_waddr, b_waddr;
  logic [BW-1:0]         a_wdata, b_wdata;
  logic [DW-1:0]         dif_r, dif_nxt;
  logic                  s2_clear;
  swaf_pkg::result_t     res;

  swaf_pkg::result_t     fifo_mem [FIFO_DEPTH];
  logic [FW-1:0]         wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]         cnt_r;
  logic                  pop;
  swaf_pkg::result_t     res_out;

  // ---------------------------------------------------------------------------
  // Accept step: control state, ring access and status
  // ---------------------------------------------------------------------------
  assign accept    = in_tvalid && in_tready;
  assign kind      = swaf_pkg::kind_t'(in_tuser);
  assign letter    = in_tdata[LW-1:0];
  assign letter_ok = int'(letter) < ALPHABET_SIZE;

  assign full     = wrapped_r || (pos_r >= TW'(pat_len_r));
  assign pos_plus = pos_r + TW'(1);
  // Slot of the letter that entered pattern-length words ago.
  assign old_sum  = SW'(head_r) + SW'(MAX_PATTERN) - SW'(pat_len_r);
  assign old_slot = (old_sum >= SW'(MAX_PATTERN)) ? RW'(old_sum - SW'(MAX_PATTERN))
                                                  : RW'(old_sum);
  assign head_inc = (int'(head_r) == MAX_PATTERN - 1) ? '0 : head_r + RW'(1);

  always_comb begin
    pat_len_nxt = pat_len_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    head_nxt    = head_r;
    wrapped_nxt = wrapped_r;
    ring_we     = 1'b0;
    s1_nxt      = '{op: swaf_pkg::OP_NONE, letter: letter, full: full,
                    win_done: 1'b0, start: '0, status: 1'b0};
    if (accept) begin
      unique case (kind)
        swaf_pkg::KIND_CLEAR: begin
          pat_len_nxt = '0;
          pos_nxt     = '0;
          started_nxt = 1'b0;
          head_nxt    = '0;
          wrapped_nxt = 1'b0;
          s1_nxt.op   = swaf_pkg::OP_CLEAR;
        end
        swaf_pkg::KIND_PATTERN: begin
          if (!letter_ok || started_r || int'(pat_len_r) >= MAX_PATTERN) begin
            s1_nxt.status = 1'b1;
          end else begin
            pat_len_nxt = pat_len_r + PW'(1);
            s1_nxt.op   = swaf_pkg::OP_PATTERN;
          end
        end
        swaf_pkg::KIND_TEXT: begin
          if (!letter_ok) begin
            s1_nxt.status = 1'b1;
          end else begin
            started_nxt = 1'b1;
            pos_nxt     = pos_plus;
            if (pos_plus == '0) begin
              wrapped_nxt = 1'b1;
            end
            // An empty pattern leaves the window empty and never matches.
            if (pat_len_r != '0) begin
              ring_we         = 1'b1;
              head_nxt        = head_inc;
              s1_nxt.op       = swaf_pkg::OP_TEXT;
              s1_nxt.win_done = full || (pos_plus >= TW'(pat_len_r));
              s1_nxt.start    = pos_plus - TW'(pat_len_r);
            end
          end
        end
        default: begin
          s1_nxt.status = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      pos_r     <= '0;
      started_r <= 1'b0;
      head_r    <= '0;
      wrapped_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      pat_len_r <= pat_len_nxt;
      pos_r     <= pos_nxt;
      started_r <= started_nxt;
      head_r    <= head_nxt;
      wrapped_r <= wrapped_nxt;
      s1_v_r    <= accept;
      s2_v_r    <= s1_v_r;
    end
  end

  // Pipeline payload needs no reset.
  always_ff @(posedge clk) begin
    s1_r      <= s1_nxt;
    s2_r      <= s1_r;
    s2_gone_r <= ring_q_r;
  end

  // Letter ring: read-first, so a full-size pattern sees the departing letter.
  always_ff @(posedge clk) begin
    ring_q_r <= ring_mem[old_slot];
    if (ring_we) begin
      ring_mem[head_r] <= letter;
    end
  end

  // ---------------------------------------------------------------------------
  // Counter memories: A counts entering text letters, B counts pattern letters
  // and leaving text letters. The balance of a letter is A minus B.
  // ---------------------------------------------------------------------------
  assign idx_l1 = AW'(s1_r.letter);
  assign idx_g1 = AW'(ring_q_r);
  assign idx_l2 = AW'(s2_r.letter);
  assign idx_g2 = AW'(s2_gone_r);

  always_ff @(posedge clk) begin
    a_l_q_r <= cnt_a_mem[idx_l1];
    a_g_q_r <= cnt_a_mem[idx_g1];
    if (a_we) begin
      cnt_a_mem[a_waddr] <= a_wdata;
    end
  end

  always_ff @(posedge clk) begin
    b_l_q_r <= cnt_b_mem[idx_l1];
    b_g_q_r <= cnt_b_mem[idx_g1];
    if (b_we) begin
      cnt_b_mem[b_waddr] <= b_wdata;
    end
  end

  // Counter values seen by the update step: the write of the previous cycle is
  // forwarded, and an entry not written since clear reads as zero.
  always_comb begin
    if (a_byp_v_r && a_byp_addr_r == idx_l2) a_l = a_byp_data_r;
    else if (a_valid_r[idx_l2])              a_l = a_l_q_r;
    else                                     a_l = '0;
    if (a_byp_v_r && a_byp_addr_r == idx_g2) a_g = a_byp_data_r;
    else if (a_valid_r[idx_g2])              a_g = a_g_q_r;
    else                                     a_g = '0;
    if (b_byp_v_r && b_byp_addr_r == idx_l2) b_l = b_byp_data_r;
    else if (b_valid_r[idx_l2])              b_l = b_l_q_r;
    else                                     b_l = '0;
    if (b_byp_v_r && b_byp_addr_r == idx_g2) b_g = b_byp_data_r;
    else if (b_valid_r[idx_g2])              b_g = b_g_q_r;
    else                                     b_g = '0;
  end

  assign bal_l = a_l - b_l;
  assign bal_g = a_g - b_g;

  // Balance update and count of letters whose balance is nonzero.
  always_comb begin
    a_we     = 1'b0;
    b_we     = 1'b0;
    a_waddr  = idx_l2;
    b_waddr  = idx_l2;
    a_wdata  = a_l + BW'(1);
    b_wdata  = b_l + BW'(1);
    dif_nxt  = dif_r;
    s2_clear = 1'b0;
    if (s2_v_r) begin
      unique case (s2_r.op)
        swaf_pkg::OP_CLEAR: begin
          s2_clear = 1'b1;
          dif_nxt  = '0;
        end
        swaf_pkg::OP_PATTERN: begin
          b_we = 1'b1;
          if (bal_l == BW'(1))   dif_nxt = dif_r - DW'(1);
          else if (bal_l == '0)  dif_nxt = dif_r + DW'(1);
        end
        swaf_pkg::OP_TEXT: begin
          a_we = 1'b1;
          if (s2_r.full) begin
            b_we    = 1'b1;
            b_waddr = idx_g2;
            b_wdata = b_g + BW'(1);
          end
          // A letter that enters and leaves at once leaves the count unchanged.
          if (!(s2_r.full && s2_gone_r == s2_r.letter)) begin
            if (bal_l == '1)       dif_nxt = dif_r - DW'(1);
            else if (bal_l == '0)  dif_nxt = dif_r + DW'(1);
            if (s2_r.full) begin
              if (bal_g == BW'(1)) begin
                dif_nxt = dif_nxt - DW'(1);
              end else if (bal_g == '0) begin
                dif_nxt = dif_nxt + DW'(1);
              end
            end
          end
        end
        swaf_pkg::OP_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= '0;
      b_valid_r <= '0;
      a_byp_v_r <= 1'b0;
      b_byp_v_r <= 1'b0;
      dif_r     <= '0;
    end else begin
      a_byp_v_r <= a_we;
      b_byp_v_r <= b_we;
      dif_r     <= dif_nxt;
      if (s2_clear) begin
        a_valid_r <= '0;
        b_valid_r <= '0;
      end else begin
        if (a_we) a_valid_r[a_waddr] <= 1'b1;
        if (b_we) b_valid_r[b_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_byp_addr_r <= a_waddr;
    a_byp_data_r <= a_wdata;
    b_byp_addr_r <= b_waddr;
    b_byp_data_r <= b_wdata;
  end

  // Result of the word in the update step.
  always_comb begin
    res.status       = s2_r.status;
    res.match        = (s2_r.op == swaf_pkg::OP_TEXT) && s2_r.win_done && (dif_nxt == '0);
    res.window_start = res.match ? s2_r.start : '0;
  end

  // ---------------------------------------------------------------------------
  // Result queue; input is held back while queue plus pipeline would overfill.
  // ---------------------------------------------------------------------------
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = cnt_r != '0;
  assign res_out    = fifo_mem[rd_ptr_r];
  assign out_tdata  = {(swaf_pkg::OUT_TDATA_W - TW - 1)'(0), res_out.window_start,
                       res_out.match};
  assign out_tuser  = res_out.status;
  assign in_tready  = (cnt_r + CW'(s1_v_r) + CW'(s2_v_r)) < CW'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (s2_v_r) wr_ptr_r <= wr_ptr_r + FW'(1);
      if (pop)    rd_ptr_r <= rd_ptr_r + FW'(1);
      cnt_r <= cnt_r + CW'(s2_v_r) - CW'(pop);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The credit check on in_tready keeps a slot free for every word in flight.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> cnt_r < CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // The nonzero-letter count never exceeds the alphabet.
  a_dif_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(dif_r) <= ALPHABET_SIZE)
    else $error("letter difference count out of range");

  // A clear leaves no counter valid and no difference.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    s2_clear |=> (dif_r == '0) && (a_valid_r == '0) && (b_valid_r == '0))
    else $error("clear did not empty the counters");

  // Only an accepted text letter can report a match.
  a_match_text: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && res.match) |-> (!res.status && s2_r.op == swaf_pkg::OP_TEXT))
    else $error("match on a word that is not an accepted text letter");

  // A forwarded counter entry has been marked valid.
  a_bypass_valid: assert property (@(posedge clk) disable iff (!rst_n)
    a_byp_v_r |-> a_valid_r[a_byp_addr_r])
    else $error("forwarded counter entry is not valid");

endmodule

`default_nettype wire

// File: tb/sv/sliding_window_anagram_finder_core_test.sv
// Self-checking testbench for sliding_window_anagram_finder_core: streams clear, pattern and
// text words, computes every expected result in an in-house anagram counter model and checks
// each result word field by field under random stalls on both streams. Needs swaf_pkg and the core.
module sliding_window_anagram_finder_core_test;

  // Names taken from the shared package.
  localparam int KIND_W      = swaf_pkg::KIND_W;
  localparam int LETTER_W    = swaf_pkg::LETTER_W;
  localparam int IN_TDATA_W  = swaf_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = swaf_pkg::OUT_TDATA_W;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = swaf_pkg::KIND_CLEAR;
  localparam logic [KIND_W-1:0] KIND_PATTERN = swaf_pkg::KIND_PATTERN;
  localparam logic [KIND_W-1:0] KIND_TEXT    = swaf_pkg::KIND_TEXT;
  typedef swaf_pkg::result_t result_t;

  localparam int MAX_PAT   = 256;
  localparam int ALPHABET  = 26;
  localparam int LONG_HOLD = 60;   // cycles the sink refuses results once
  localparam int HOLD_AT   = 120;  // words accepted before that hold-off
  localparam int CALM_AT   = 800;  // words accepted before idling stops
  localparam int WORD_GOAL = 950;
  localparam int EXP_DEPTH = 64;   // ring of expected results, far above the words in flight

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = KIND_CLEAR;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Run control shared by the stimulus, sink and checker.
  result_t expected_words [EXP_DEPTH];
  int      exp_wr         = 0;
  int      exp_rd         = 0;
  int      words_accepted = 0;
  int      mismatch_count = 0;
  bit      calm           = 1'b0;
  bit      sender_idles   = 1'b1;
  bit      receiver_idles = 1'b1;

  // Model of the finder: balance is window count minus pattern count per letter.
  int          balance [ALPHABET];
  int          unbalanced_letters;
  logic [4:0]  recent_text [MAX_PAT];
  int          pattern_len;
  logic [31:0] text_count;
  bit          text_begun;
  int          ring_slot;
  bit          count_wrapped;

  // Opening words; a set typed flag means the expected result is given here.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;
    logic                typed;
    result_t             want;
  } opening_t;

  opening_t opening_words [0:24] = '{
    '{KIND_TEXT,    5'd2,  1'b1, '{1'b0, 32'd0, STATUS_OK}},      // text with empty pattern
    '{KIND_CLEAR,   5'd31, 1'b1, '{1'b0, 32'd0, STATUS_OK}},
    '{KIND_UNUSED,  5'd31, 1'b1, '{1'b0, 32'd0, STATUS_IGNORED}},
    '{KIND_PATTERN, 5'd31, 1'b1, '{1'b0, 32'd0, STATUS_IGNORED}}, // letter out of range
    '{KIND_PATTERN, 5'd26, 1'b1, '{1'b0, 32'd0, STATUS_IGNORED}},
    '{KIND_PATTERN, 5'd0,  1'b1, '{1'b0, 32'd0, STATUS_OK}},
    '{KIND_PATTERN, 5'd25, 1'b1, '{1'b0, 32'd0, STATUS_OK}},
    '{KIND_PATTERN, 5'd1,  1'b1, '{1'b0, 32'd0, STATUS_OK}},
    '{KIND_TEXT,    5'd30, 1'b1, '{1'b0, 32'd0, STATUS_IGNORED}},
    '{KIND_TEXT,    5'd25, 1'b0, '0},
    '{KIND_TEXT,    5'd1,  1'b0, '0},
    '{KIND_TEXT,    5'd0,  1'b0, '0},
    '{KIND_TEXT,    5'd25, 1'b0, '0},
    '{KIND_TEXT,    5'd2,  1'b0, '0},
    '{KIND_PATTERN, 5'd3,  1'b1, '{1'b0, 32'd0, STATUS_IGNORED}}, // pattern after text
    '{KIND_TEXT,    5'd0,  1'b0, '0},
    '{KIND_TEXT,    5'd1,  1'b0, '0},
    '{KIND_UNUSED,  5'd0,  1'b1, '{1'b0, 32'd0, STATUS_IGNORED}},
    '{KIND_CLEAR,   5'd0,  1'b1, '{1'b0, 32'd0, STATUS_OK}},
    '{KIND_PATTERN, 5'd7,  1'b1, '{1'b0, 32'd0, STATUS_OK}},
    '{KIND_TEXT,    5'd7,  1'b0, '0},
    '{KIND_TEXT,    5'd7,  1'b0, '0},
    '{KIND_TEXT,    5'd16, 1'b0, '0},
    '{KIND_TEXT,    5'd15, 1'b0, '0},
    '{KIND_CLEAR,   5'd0,  1'b1, '{1'b0, 32'd0, STATUS_OK}}
  };

  sliding_window_anagram_finder_core #(
    .MAX_PATTERN   (MAX_PAT),
    .ALPHABET_SIZE (ALPHABET)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Return the model to its empty state.
  function automatic void clear_counts();
    foreach (balance[i]) balance[i] = 0;
    foreach (recent_text[i]) recent_text[i] = '0;
    unbalanced_letters = 0;
    pattern_len        = 0;
    text_count         = '0;
    text_begun         = 1'b0;
    ring_slot          = 0;
    count_wrapped      = 1'b0;
  endfunction

  function automatic void raise_balance(int l);
    if (balance[l] == -1) unbalanced_letters--;
    else if (balance[l] == 0) unbalanced_letters++;
    balance[l]++;
  endfunction

  function automatic void lower_balance(int l);
    if (balance[l] == 1) unbalanced_letters--;
    else if (balance[l] == 0) unbalanced_letters++;
    balance[l]--;
  endfunction

  // Append one expected result word behind the ones still outstanding.
  function automatic void expect_word(result_t r);
    expected_words[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  // Apply one word to the model and return the result word it must produce.
  function automatic result_t anagram_result(logic [KIND_W-1:0] kind,
                                             logic [LETTER_W-1:0] letter);
    result_t r;
    bit      full;
    int      old_slot;
    r = '0;
    case (kind)
      KIND_CLEAR: begin
        clear_counts();
      end
      KIND_PATTERN: begin
        if (letter >= ALPHABET || text_begun || pattern_len >= MAX_PAT) begin
          r.status = STATUS_IGNORED;
        end else begin
          lower_balance(letter);
          pattern_len++;
        end
      end
      KIND_TEXT: begin
        if (letter >= ALPHABET) begin
          r.status = STATUS_IGNORED;
        end else begin
          text_begun = 1'b1;
          if (pattern_len > 0) begin
            full = count_wrapped || (text_count >= pattern_len);
            raise_balance(letter);
            // The letter that entered pattern_len words ago leaves the window.
            if (full) begin
              old_slot = (ring_slot + MAX_PAT - pattern_len) % MAX_PAT;
              lower_balance(recent_text[old_slot]);
            end
            recent_text[ring_slot] = letter;
            ring_slot = (ring_slot + 1) % MAX_PAT;
            if ((full || text_count + 32'd1 >= pattern_len) && unbalanced_letters == 0) begin
              r.match        = 1'b1;
              r.window_start = text_count + 32'd1 - pattern_len;
            end
          end
          text_count++;
          if (text_count == 0) count_wrapped = 1'b1;
        end
      end
      default: begin
        r.status = STATUS_IGNORED;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s is %0d, expected %0d", $time, field, got, want);
  endtask

  // Offer one word and return at the edge where it is accepted.
  task automatic send_word(logic [KIND_W-1:0] kind, logic [LETTER_W-1:0] letter);
    int gap;
    gap = 0;
    if (!calm && sender_idles && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W-LETTER_W){1'b0}}, letter};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_accepted++;
  endtask

  task automatic feed(logic [KIND_W-1:0] kind, logic [LETTER_W-1:0] letter);
    send_word(kind, letter);
    expect_word(anagram_result(kind, letter));
  endtask

  // A word the block should refuse, or a late pattern letter once text has begun.
  task automatic noise_word();
    case ($urandom_range(0, 3))
      0:       feed(KIND_UNUSED, LETTER_W'($urandom_range(0, 31)));
      1:       feed(KIND_PATTERN, LETTER_W'($urandom_range(ALPHABET, 31)));
      2:       feed(KIND_TEXT, LETTER_W'($urandom_range(ALPHABET, 31)));
      default: feed(KIND_PATTERN, LETTER_W'($urandom_range(0, ALPHABET - 1)));
    endcase
  endtask

  // Clear, load a pattern, then stream text, all drawn from a narrow run of letters
  // so that anagram windows show up often.
  task automatic run_sequence(int pat_n, int text_n, int span, int noise_pct);
    int base;
    base = $urandom_range(0, ALPHABET - span);
    sender_idles = ($urandom_range(0, 2) != 0);
    feed(KIND_CLEAR, LETTER_W'($urandom_range(0, 31)));
    repeat (pat_n) begin
      if ($urandom_range(1, 100) <= noise_pct) noise_word();
      feed(KIND_PATTERN, LETTER_W'(base + $urandom_range(0, span - 1)));
    end
    repeat (text_n) begin
      if ($urandom_range(1, 100) <= noise_pct) noise_word();
      feed(KIND_TEXT, LETTER_W'(base + $urandom_range(0, span - 1)));
    end
  endtask

  // Stimulus: opening words, a full-size pattern, then many short searches.
  initial begin : stimulus
    result_t want;
    clear_counts();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 25; i++) begin
      send_word(opening_words[i].kind, opening_words[i].letter);
      want = anagram_result(opening_words[i].kind, opening_words[i].letter);
      if (opening_words[i].typed) want = opening_words[i].want;
      expect_word(want);
    end

    // Let the block drain completely before going on.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_rd != exp_wr) @(posedge clk);

    // Pattern longer than the ring allows, then enough text to wrap the ring.
    run_sequence(MAX_PAT + 2, 280, 2, 2);

    while (words_accepted < CALM_AT)
      run_sequence($urandom_range(0, 6), $urandom_range(4, 30), $urandom_range(1, 4), 8);
    calm = 1'b1;
    while (words_accepted < WORD_GOAL)
      run_sequence($urandom_range(0, 6), $urandom_range(4, 30), $urandom_range(1, 4), 8);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Result sink: random stall bursts and one long hold-off that backs up the input.
  initial begin : sink
    int  stall;
    bit  hold_done;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = 0;
      if (!hold_done && words_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        stall     = LONG_HOLD;
      end else if (!calm && receiver_idles && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 11);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if ($urandom_range(0, 15) == 0) receiver_idles = !receiver_idles;
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.match        = out_tdata[0];
      got.window_start = out_tdata[32:1];
      got.status       = out_tuser;
      if (exp_rd == exp_wr) begin
        report_mismatch("unexpected result word, window_start", got.window_start, 0);
      end else begin
        want = expected_words[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got.match !== want.match)
          report_mismatch("match", got.match, want.match);
        if (got.window_start !== want.window_start)
          report_mismatch("window_start", got.window_start, want.window_start);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
      end
    end
  end

  // Hard stop in case the handshakes hang.
  initial begin : watchdog
    #(8 * 200_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/swaf_pkg.sv
rtl/sliding_window_anagram_finder_core.sv
tb/sv/sliding_window_anagram_finder_core_test.sv
